// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros, sampled on i_clk and quiet while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every sampled edge outside reset
`define SPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Antecedent at one edge implies the consequent at the next edge
`define SPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: design/sps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sps_pkg
// Types and constants shared by the sorted priority stack modules.
// ----------------------------------------------------------------------------
package sps_pkg;

    // Storage geometry
    localparam int CAPACITY   = 16;
    localparam int ELEM_WIDTH = 32;
    localparam int PRIO_WIDTH = 8;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // Fixed field widths of the request channels
    localparam int CMD_W       = 2;
    localparam int IN_ELEM_W   = 32;
    localparam int IN_PRIO_W   = 8;
    localparam int OUT_CNT_W   = 5;
    localparam int ERR_W       = 2;

    // Operation codes
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [IN_ELEM_W-1:0] elem;
        logic [IN_PRIO_W-1:0] priority_req;
    } t_in_req;

    typedef struct packed {
        logic [IN_ELEM_W-1:0] top_elem;
        logic [IN_PRIO_W-1:0] top_priority;
        logic [OUT_CNT_W-1:0] entry_count;
        logic                 is_empty;
        logic [ERR_W-1:0]     error;
    } t_out_req;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture the incoming request
        logic commit;  // apply the operation and register the result
    } t_dp_cmd;

endpackage

`default_nettype wire

// File: design/sps_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// sps_ctrl
// Two-state sequencer: takes a request, then commits it once the output
// register is free. Owns the output valid flag.
// ----------------------------------------------------------------------------
module sps_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output sps_pkg::t_dp_cmd     o_cmd
);
    import sps_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // Output slot is free when empty or being taken this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.commit = out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // Output valid: set by a commit, cleared when the request is taken
    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // Assertions
    `SPS_ASSERT_NEXT(a_load_to_exec, o_cmd.load, r_state == ST_EXEC,
        "accepted request did not start execution")
    `SPS_ASSERT(a_no_overwrite, !(o_cmd.commit && r_out_valid && i_out_stall),
        "commit would overwrite a stalled result")
    `SPS_ASSERT_NEXT(a_hold_exec, (r_state == ST_EXEC) && !out_free,
        (r_state == ST_EXEC) && r_out_valid,
        "execution left while output was blocked")

endmodule

`default_nettype wire

// File: design/sps_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// sps_datapath
// Row of storage cells kept sorted by descending priority. Every cell
// compares its priority with the request in parallel; a push shifts the
// lower part down by one, a pop shifts everything up by one.
// ----------------------------------------------------------------------------
module sps_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sps_pkg::t_in_req   i_in_req,
    input  wire sps_pkg::t_dp_cmd   i_cmd,
    output sps_pkg::t_out_req       o_out_req
);
    import sps_pkg::*;

    // Cells, count, captured request, result register
    logic [ELEM_WIDTH-1:0] r_elem [CAPACITY];
    logic [PRIO_WIDTH-1:0] r_prio [CAPACITY];
    logic [ELEM_WIDTH-1:0] n_elem [CAPACITY];
    logic [PRIO_WIDTH-1:0] n_prio [CAPACITY];
    logic [CNT_W-1:0]      r_count, n_count;
    t_in_req               r_op;
    t_out_req              r_res, n_res;

    logic [ELEM_WIDTH-1:0] op_elem;
    logic [PRIO_WIDTH-1:0] op_prio;
    logic                  is_push, is_pop, is_clear;
    logic                  full, empty;
    logic                  do_push, do_pop;
    logic [CAPACITY-1:0]   higher;   // cell holds a strictly higher priority
    logic [CAPACITY-1:0]   at_pos;   // head or cell below a higher one: insert point if not higher

    // Decode the captured request
    assign op_elem  = ELEM_WIDTH'(r_op.elem);
    assign op_prio  = PRIO_WIDTH'(r_op.priority_req);
    assign is_push  = (r_op.cmd == CMD_PUSH);
    assign is_pop   = (r_op.cmd == CMD_POP);
    assign is_clear = (r_op.cmd == CMD_CLEAR);
    assign full     = (r_count == CNT_W'(CAPACITY));
    assign empty    = (r_count == '0);
    assign do_push  = is_push && !full;
    assign do_pop   = is_pop && !empty;

    // Per-cell compare and shift
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        assign higher[i] = (CNT_W'(i) < r_count) && (r_prio[i] > op_prio);

        if (i == 0) begin : g_head
            assign at_pos[i] = 1'b1;
        end else begin : g_body
            assign at_pos[i] = higher[i-1];
        end

        logic [ELEM_WIDTH-1:0] dn_elem, up_elem;
        logic [PRIO_WIDTH-1:0] dn_prio, up_prio;

        // Neighbor above feeds a push shift
        if (i == 0) begin : g_dn_head
            assign dn_elem = op_elem;
            assign dn_prio = op_prio;
        end else begin : g_dn_body
            assign dn_elem = r_elem[i-1];
            assign dn_prio = r_prio[i-1];
        end

        // Neighbor below feeds a pop shift
        if (i == CAPACITY - 1) begin : g_up_tail
            assign up_elem = r_elem[i];
            assign up_prio = r_prio[i];
        end else begin : g_up_body
            assign up_elem = r_elem[i+1];
            assign up_prio = r_prio[i+1];
        end

        always_comb begin
            n_elem[i] = r_elem[i];
            n_prio[i] = r_prio[i];
            if (do_push && !higher[i]) begin
                n_elem[i] = at_pos[i] ? op_elem : dn_elem;
                n_prio[i] = at_pos[i] ? op_prio : dn_prio;
            end else if (do_pop) begin
                n_elem[i] = up_elem;
                n_prio[i] = up_prio;
            end
        end
    end

    // Next count
    always_comb begin
        n_count = r_count;
        if (do_push) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop) begin
            n_count = r_count - CNT_W'(1);
        end else if (is_clear) begin
            n_count = '0;
        end
    end

    // Result describes the store after the operation
    always_comb begin
        n_res              = '0;
        n_res.entry_count  = OUT_CNT_W'(n_count);
        n_res.is_empty     = (n_count == '0);
        if (n_count != '0) begin
            n_res.top_elem     = IN_ELEM_W'(n_elem[0]);
            n_res.top_priority = IN_PRIO_W'(n_prio[0]);
        end
        if (is_push && full) begin
            n_res.error = ERR_FULL;
        end else if (is_pop && empty) begin
            n_res.error = ERR_EMPTY;
        end else begin
            n_res.error = ERR_OK;
        end
    end

    // Count is control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_in_req;
        end
        if (i_cmd.commit) begin
            r_res <= n_res;
            for (int k = 0; k < CAPACITY; k++) begin
                r_elem[k] <= n_elem[k];
                r_prio[k] <= n_prio[k];
            end
        end
    end

    assign o_out_req = r_res;

    // Assertions
    `SPS_ASSERT(a_count_range, r_count <= CNT_W'(CAPACITY),
        "stored count exceeds capacity")
    `SPS_ASSERT_NEXT(a_full_hold, i_cmd.commit && is_push && full,
        $stable(r_count) && (r_res.error == ERR_FULL),
        "push on full store changed the count")
    `SPS_ASSERT_NEXT(a_res_count, i_cmd.commit,
        (r_res.entry_count == OUT_CNT_W'(r_count)) &&
        (r_res.is_empty == (r_count == '0)),
        "result count does not match the store")

endmodule

`default_nettype wire

// File: design/sorted_priority_stack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_stack
// Bounded store of element and priority pairs sorted by descending priority.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_req) carries one command:
//   push, pop front or clear. Output channel (o_out_valid / i_out_stall /
//   o_out_req) returns one result per request: front element and priority,
//   count, empty flag and error code, all as after the operation.
//   A push goes ahead of every stored pair of lower or equal priority, so
//   equal priorities leave last in, first out. Pop on an empty store and
//   push on a full store flag an error and leave the store untouched.
//   A request accepted in ST_IDLE is captured, then committed in ST_EXEC
//   once the output register is free; its result is valid from then on.
//   No new request is taken before it commits: the capture, then the
//   parallel compare-and-shift of the cell row into the result register.
//   If the receiver stalls, the result holds in the output register; the
//   block still takes the next request but waits to commit it until the
//   output register frees up.
//   Reset clears the count and the handshake state, not the cells or the
//   result register; o_out_req may show old data while not valid.
// ----------------------------------------------------------------------------
module sorted_priority_stack (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire sps_pkg::t_in_req   i_in_req,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output sps_pkg::t_out_req       o_out_req
);
    import sps_pkg::*;

    t_dp_cmd dp_cmd;

    // Sequencer
    sps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd)
    );

    // Cell row and result register
    sps_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_req  (i_in_req),
        .i_cmd     (dp_cmd),
        .o_out_req (o_out_req)
    );

endmodule

`default_nettype wire
